[rtl/per_peer_slot_rate_limiter_unit_defines.svh]
// Assertion macros for the per-peer slot rate limiter.
`ifndef PER_PEER_SLOT_RATE_LIMITER_UNIT_DEFINES_SVH
`define PER_PEER_SLOT_RATE_LIMITER_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define PPSRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define PPSRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/ppsrl_pkg.sv]
// Package: types, constants and state codes of the per-peer slot rate limiter.
package ppsrl_pkg;
    localparam int SLOTS = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] FUNC_ADMIT    = 2'd0;
    localparam logic [1:0] FUNC_ANNOUNCE = 2'd1;
    localparam logic [1:0] FUNC_READ     = 2'd2;
    localparam logic [1:0] FUNC_COMMIT   = 2'd3;

    localparam logic [2:0] REG_WINDOW   = 3'd0;
    localparam logic [2:0] REG_PEER_LIM = 3'd1;
    localparam logic [2:0] REG_TOT_LIM  = 3'd2;
    localparam logic [2:0] REG_ANNOUNCE = 3'd3;
    localparam logic [2:0] REG_PROTECT  = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [62:0] peer_id;
        logic [62:0] now;
        logic [62:0] expected_cursor;
        logic [62:0] page_last_seq;
        logic        page_empty;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [62:0] cursor;
    } t_out_item;

    typedef struct packed {
        logic        used;
        logic [62:0] peer;
        logic [62:0] win_begin;
        logic [62:0] announced_at;
        logic [62:0] seen_at;
        logic [62:0] cursor;
        logic [15:0] frames;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } t_state;

    // Signed elapsed check; operands below 2^63 so 64-bit difference is exact.
    function automatic logic elapsed_ge(logic [62:0] now_t, logic [62:0] then_t,
                                        logic [15:0] bound);
        logic signed [63:0] d;
        d = $signed({1'b0, now_t}) - $signed({1'b0, then_t});
        return d >= $signed({48'd0, bound});
    endfunction
endpackage

[rtl/per_peer_slot_rate_limiter_unit.sv]
// Top level of the per-peer slot rate limiter.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+--------------------------
//   request | i_in_valid   | o_in_ready   | i_in_data  (t_in_item)
//   result  | o_out_valid  | i_out_ready  | o_out_data (t_out_item)
//   config  | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// After reset a clearing pass walks the slot memory, one slot a cycle; no
// request is taken meanwhile. After the request transfer the scan reads one
// slot per cycle from the slot memory (one read port, one write port), then
// the chosen slot is read, modified and written back. A new request is taken
// only once the block is idle and the last result has been taken. The result
// waits in an output register; a stalled result holds the next request off,
// config transfers are always taken.
module per_peer_slot_rate_limiter_unit
    import ppsrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
`include "per_peer_slot_rate_limiter_unit_defines.svh"

    // Slot memory: one wide word per slot, registered read.
    t_slot       mem [SLOTS];
    t_slot       r_rd;
    logic [SLOT_W-1:0] rd_addr;
    logic        wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_slot       wr_data;

    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_in_item    r_req;
    logic        r_hit, r_free_f, r_stale_f;
    logic [SLOT_W-1:0] r_hit_i, r_free_i, r_stale_i;
    logic        r_pick_ok, r_claim;
    logic [SLOT_W-1:0] r_pick;
    logic [SLOT_W-1:0] pick_idx;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] r_window, r_plim, r_tlim, r_annc, r_prot;
    logic [62:0] r_gstart;
    logic [15:0] r_gframes;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 16'd60;
            r_plim   <= 16'd64;
            r_tlim   <= 16'd1024;
            r_annc   <= 16'd30;
            r_prot   <= 16'd120;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW:   r_window <= i_cfg_data;
                REG_PEER_LIM: r_plim   <= i_cfg_data;
                REG_TOT_LIM:  r_tlim   <= i_cfg_data;
                REG_ANNOUNCE: r_annc   <= i_cfg_data;
                REG_PROTECT:  r_prot   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SLOTS)) n_state = ST_READ;
            end
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Pick the slot once the scan flags are final: hit, else free, else stale.
    assign pick_idx = r_hit ? r_hit_i : (r_free_f ? r_free_i : r_stale_i);

    // Memory address and write controls.
    logic  ex_ok;
    t_slot ex_slot;
    logic  ex_gwin;
    always_comb begin
        rd_addr = r_cnt[SLOT_W-1:0];
        if (r_state == ST_READ) rd_addr = pick_idx;
        wr_en   = 1'b0;
        wr_addr = r_cnt[SLOT_W-1:0];
        wr_data = '0;
        if (r_state == ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_state == ST_EXEC && r_pick_ok) begin
            wr_en   = 1'b1;
            wr_addr = r_pick;
            wr_data = ex_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    // Scan: data of slot r_cnt-1 is in r_rd during ST_SCAN with r_cnt >= 1.
    logic scan_v;
    assign scan_v = (r_state == ST_SCAN) && (r_cnt != '0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0; r_free_f <= 1'b0; r_stale_f <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_hit <= 1'b0; r_free_f <= 1'b0; r_stale_f <= 1'b0;
        end else if (scan_v) begin
            if (!r_hit && r_rd.used && r_rd.peer == r_req.peer_id) begin
                r_hit <= 1'b1; r_hit_i <= r_cnt[SLOT_W-1:0] - SLOT_W'(1);
            end
            if (!r_free_f && !r_rd.used) begin
                r_free_f <= 1'b1; r_free_i <= r_cnt[SLOT_W-1:0] - SLOT_W'(1);
            end
            if (!r_stale_f && r_rd.used &&
                elapsed_ge(r_req.now, r_rd.seen_at, r_prot)) begin
                r_stale_f <= 1'b1; r_stale_i <= r_cnt[SLOT_W-1:0] - SLOT_W'(1);
            end
        end
    end

    logic claimable;
    assign claimable = (r_req.func == FUNC_ADMIT) || (r_req.func == FUNC_ANNOUNCE);
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_req <= i_in_data;
        if (r_state == ST_READ) begin
            r_claim   <= !r_hit;
            r_pick_ok <= r_hit || (claimable && (r_free_f || r_stale_f));
            r_pick    <= pick_idx;
        end
    end

    // Execute: modify the picked slot.
    t_slot base;
    logic  pwin;
    always_comb begin
        base = r_rd;
        if (r_claim) begin
            base = '0;
            base.used = 1'b1;
            base.peer = r_req.peer_id;
            base.win_begin = r_req.now;
            base.seen_at   = r_req.now;
        end
        ex_slot = base;
        ex_ok   = 1'b0;
        pwin    = elapsed_ge(r_req.now, base.win_begin, r_window);
        ex_gwin = elapsed_ge(r_req.now, r_gstart, r_window);
        case (r_req.func)
            FUNC_ADMIT: begin
                ex_slot.seen_at = r_req.now;
                if (pwin) begin
                    ex_slot.win_begin = r_req.now;
                    ex_slot.frames = '0;
                end
                ex_ok = (ex_slot.frames < r_plim) &&
                        ((ex_gwin ? 16'd0 : r_gframes) < r_tlim);
                if (ex_ok) ex_slot.frames = ex_slot.frames + 16'd1;
            end
            FUNC_ANNOUNCE: begin
                ex_slot.seen_at = r_req.now;
                ex_ok = elapsed_ge(r_req.now, base.announced_at, r_annc);
                if (ex_ok) ex_slot.announced_at = r_req.now;
            end
            FUNC_READ: ex_ok = 1'b1;
            default: begin
                ex_ok = (base.cursor == r_req.expected_cursor) &&
                        (r_req.page_empty || r_req.page_last_seq != '0);
                if (ex_ok) ex_slot.cursor = r_req.page_empty ? '0 : r_req.page_last_seq;
            end
        endcase
    end

    // Global window and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gstart    <= '0;
            r_gframes   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_EXEC) begin
                r_out.ok     <= r_pick_ok && ex_ok;
                r_out.cursor <= (r_pick_ok && r_req.func == FUNC_READ) ? base.cursor : '0;
                if (r_pick_ok && r_req.func == FUNC_ADMIT) begin
                    if (ex_gwin) r_gstart <= r_req.now;
                    r_gframes <= (ex_gwin ? 16'd0 : r_gframes) + {15'd0, ex_ok};
                end
            end
            if (r_state == ST_OUT) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
        end
    end

    `PPSRL_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n,
        (r_state != ST_IDLE), !o_in_ready)
    `PPSRL_ASSERT_NXT(a_out_after_exec, i_clk, i_rst_n,
        (r_state == ST_OUT), o_out_valid)
    `PPSRL_ASSERT_IMP(a_limit_held, i_clk, i_rst_n,
        (r_state == ST_EXEC && r_pick_ok && ex_ok && r_req.func == FUNC_ADMIT),
        (r_gframes < r_tlim) || ex_gwin)
endmodule

[bench/tb_top.sv]
// Testbench for the per-peer slot rate limiter: random and directed requests.
`timescale 1ns / 100ps
module tb_top;
    import ppsrl_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    per_peer_slot_rate_limiter_unit dut (.*);

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the block's state and registers.
    logic [15:0] win_len, peer_lim, tot_lim, ann_per, prot_len;
    t_slot       pool [SLOTS];
    logic [62:0] glob_start;
    logic [15:0] glob_frames;

    t_in_item    pending_reqs [$];
    t_out_item   awaited_results [$];
    int          send_idle_pct, recv_idle_pct;
    int          hold_off_cycles;
    int          errors;
    longint      cycle_count;

    function automatic bit aged(logic [62:0] now_t, logic [62:0] then_t, logic [15:0] bnd);
        longint d;
        d = longint'({1'b0, now_t}) - longint'({1'b0, then_t});
        return d >= longint'({48'd0, bnd});
    endfunction

    function automatic int lookup_peer(logic [62:0] peer);
        for (int i = 0; i < SLOTS; i++)
            if (pool[i].used && pool[i].peer == peer) return i;
        return -1;
    endfunction

    function automatic int lookup_or_claim(logic [62:0] peer, logic [62:0] now_t);
        int free_i, stale_i, pick;
        free_i = -1;
        stale_i = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (pool[i].used && pool[i].peer == peer) return i;
            if (!pool[i].used && free_i < 0) free_i = i;
            if (pool[i].used && stale_i < 0 && aged(now_t, pool[i].seen_at, prot_len))
                stale_i = i;
        end
        if (free_i < 0 && stale_i < 0) return -1;
        pick = (free_i >= 0) ? free_i : stale_i;
        pool[pick] = '0;
        pool[pick].used = 1'b1;
        pool[pick].peer = peer;
        pool[pick].win_begin = now_t;
        pool[pick].seen_at = now_t;
        return pick;
    endfunction

    // Apply one request to the predicted state and return its result.
    function automatic t_out_item police_request(t_in_item r);
        t_out_item res;
        int s;
        res = '0;
        case (r.func)
            FUNC_ADMIT: begin
                s = lookup_or_claim(r.peer_id, r.now);
                if (s >= 0) begin
                    pool[s].seen_at = r.now;
                    if (aged(r.now, pool[s].win_begin, win_len)) begin
                        pool[s].win_begin = r.now;
                        pool[s].frames = '0;
                    end
                    if (aged(r.now, glob_start, win_len)) begin
                        glob_start = r.now;
                        glob_frames = '0;
                    end
                    res.ok = (pool[s].frames < peer_lim) && (glob_frames < tot_lim);
                    if (res.ok) begin
                        pool[s].frames++;
                        glob_frames++;
                    end
                end
            end
            FUNC_ANNOUNCE: begin
                s = lookup_or_claim(r.peer_id, r.now);
                if (s >= 0) begin
                    pool[s].seen_at = r.now;
                    res.ok = aged(r.now, pool[s].announced_at, ann_per);
                    if (res.ok) pool[s].announced_at = r.now;
                end
            end
            FUNC_READ: begin
                s = lookup_peer(r.peer_id);
                if (s >= 0) begin
                    res.ok = 1'b1;
                    res.cursor = pool[s].cursor;
                end
            end
            default: begin
                s = lookup_peer(r.peer_id);
                if (s >= 0 && pool[s].cursor == r.expected_cursor
                        && (r.page_empty || r.page_last_seq != 0)) begin
                    res.ok = 1'b1;
                    pool[s].cursor = r.page_empty ? 63'd0 : r.page_last_seq;
                end
            end
        endcase
        return res;
    endfunction

    // Driver: offer the next pending request, hold it until the transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            awaited_results.push_back(police_request(i_in_data));
            void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data <= pending_reqs[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid && pending_reqs.size() > 0
                     && $urandom_range(99) >= send_idle_pct) begin
            i_in_valid <= 1'b1;
            i_in_data <= pending_reqs[0];
        end
    end

    // Result ready: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result ok=%0d cursor=%0h", $time,
                         o_out_data.ok, o_out_data.cursor);
                errors++;
            end else begin
                if (o_out_data.ok !== awaited_results[0].ok) begin
                    $display("%0t: ok mismatch expected %0d actual %0d", $time,
                             awaited_results[0].ok, o_out_data.ok);
                    errors++;
                end
                if (o_out_data.cursor !== awaited_results[0].cursor) begin
                    $display("%0t: cursor mismatch expected %0h actual %0h", $time,
                             awaited_results[0].cursor, o_out_data.cursor);
                    errors++;
                end
                void'(awaited_results.pop_front());
            end
        end
    end

    // Watchdog: end the run at a generous cycle limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic t_in_item make_req(logic [1:0] f, logic [62:0] peer, logic [62:0] now_t);
        t_in_item r;
        r = '0;
        r.func = f;
        r.peer_id = peer;
        r.now = now_t;
        return r;
    endfunction

    task automatic drain_and_settle();
        while (pending_reqs.size() > 0 || awaited_results.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Write one register, mirror it into the predictor.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_WINDOW:   win_len = val;
            REG_PEER_LIM: peer_lim = val;
            REG_TOT_LIM:  tot_lim = val;
            REG_ANNOUNCE: ann_per = val;
            REG_PROTECT:  prot_len = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] w, logic [15:0] pl, logic [15:0] tl,
                             logic [15:0] ap, logic [15:0] pr);
        write_reg(REG_WINDOW, w);
        write_reg(REG_PEER_LIM, pl);
        write_reg(REG_TOT_LIM, tl);
        write_reg(REG_ANNOUNCE, ap);
        write_reg(REG_PROTECT, pr);
    endtask

    // Random traffic: a small peer pool, slowly advancing time with occasional jumps.
    task automatic queue_random(int count, int peer_span);
        t_in_item r;
        logic [62:0] clk_s;
        clk_s = 63'd1000 + $urandom_range(1000);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(19))
                0: clk_s = clk_s - $urandom_range(50);
                1: clk_s = clk_s + $urandom_range(500);
                2: clk_s = rand63();
                default: clk_s = clk_s + $urandom_range(3);
            endcase
            r = make_req(2'($urandom_range(3)),
                         ($urandom_range(15) == 0) ? rand63() : 63'($urandom_range(peer_span)),
                         clk_s);
            if ($urandom_range(1)) begin
                r.expected_cursor = rand63();
                r.page_last_seq = rand63();
            end else begin
                r.expected_cursor = 63'($urandom_range(3));
                r.page_last_seq = 63'($urandom_range(3));
            end
            r.page_empty = 1'($urandom_range(1));
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        t_in_item r;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        win_len = 16'd60;
        peer_lim = 16'd64;
        tot_lim = 16'd1024;
        ann_per = 16'd30;
        prot_len = 16'd120;
        for (int i = 0; i < SLOTS; i++) pool[i] = '0;
        glob_start = '0;
        glob_frames = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tight limits, every function, time going backwards, commit rules.
        write_all(16'd10, 16'd2, 16'd3, 16'd5, 16'd1);
        write_reg(3'd7, 16'hFFFF);
        pending_reqs.push_back(make_req(FUNC_READ, 63'd5, 63'd100));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'd5, 63'd100));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'd5, 63'd101));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'd5, 63'd102));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'h7FFFFFFFFFFFFFFF, 63'd103));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'd6, 63'd104));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'd5, 63'd50));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'd5, 63'd120));
        pending_reqs.push_back(make_req(FUNC_ANNOUNCE, 63'd5, 63'd121));
        pending_reqs.push_back(make_req(FUNC_ANNOUNCE, 63'd5, 63'd122));
        pending_reqs.push_back(make_req(FUNC_ANNOUNCE, 63'd5, 63'd127));
        pending_reqs.push_back(make_req(FUNC_ANNOUNCE, 63'd0, 63'h7FFFFFFFFFFFFFFF));
        r = make_req(FUNC_COMMIT, 63'd5, 63'd130);
        r.page_last_seq = 63'h7FFFFFFFFFFFFFFF;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(FUNC_READ, 63'd5, 63'd130));
        r.expected_cursor = 63'h7FFFFFFFFFFFFFFF;
        r.page_last_seq = 63'd0;
        pending_reqs.push_back(r);
        r.page_empty = 1'b1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(FUNC_READ, 63'd5, 63'd130));
        pending_reqs.push_back(make_req(FUNC_COMMIT, 63'd77, 63'd130));
        drain_and_settle();

        // Full table: fill all slots with long protection, then a newcomer is refused.
        write_all(16'd0, 16'd0, 16'd65535, 16'd0, 16'd65535);
        for (int i = 0; i < SLOTS; i++)
            pending_reqs.push_back(make_req(FUNC_ANNOUNCE, 63'(1000 + i), 63'd10));
        pending_reqs.push_back(make_req(FUNC_ADMIT, 63'd9999, 63'd20));
        pending_reqs.push_back(make_req(FUNC_ANNOUNCE, 63'd9998, 63'd20));
        drain_and_settle();

        // Long receiver hold-off while requests keep coming.
        hold_off_cycles = 2000;
        queue_random(20, 40);
        drain_and_settle();

        send_idle_pct = 32;
        recv_idle_pct = 54;
        write_all(16'd1, 16'd65535, 16'd0, 16'd65535, 16'd1);
        queue_random(350, 100);
        drain_and_settle();

        send_idle_pct = 54;
        recv_idle_pct = 32;
        write_all(16'd65535, 16'd3, 16'd40, 16'd2, 16'd5);
        queue_random(350, 80);
        drain_and_settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(16'($urandom_range(1, 20)), 16'($urandom_range(8)),
                  16'($urandom_range(60)), 16'($urandom_range(1, 10)),
                  16'($urandom_range(1, 30)));
        queue_random(350, 120);
        drain_and_settle();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/ppsrl_pkg.sv
rtl/per_peer_slot_rate_limiter_unit.sv
bench/tb_top.sv
